// ===== rtl/bank_switch_mapper_scanline_irq_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bank switch mapper
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef BANK_SWITCH_MAPPER_SCANLINE_IRQ_UNIT_DEFINES_SVH
`define BANK_SWITCH_MAPPER_SCANLINE_IRQ_UNIT_DEFINES_SVH

// same-cycle implication
`define BSM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bsm check failed: same-cycle rule");

// next-cycle implication
`define BSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bsm check failed: next-cycle rule");

`endif

// ===== rtl/bsm_pkg.sv =====
// ----------------------------------------------------------------------------
// bsm_pkg
// Event kinds, memory targets and configuration indexes of the mapper.
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int unsigned AddrW   = 16;
  localparam int unsigned DataW   = 8;
  localparam int unsigned OffsetW = 19;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 7;

  typedef enum logic [1:0] {
    KIND_CPU_WRITE = 2'd0,
    KIND_CPU_MAP   = 2'd1,
    KIND_PPU_MAP   = 2'd2,
    KIND_A12_EDGE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    TGT_NONE      = 3'd0,
    TGT_CPU_RAM   = 3'd1,
    TGT_PRG_RAM   = 3'd2,
    TGT_PRG_ROM   = 3'd3,
    TGT_CHR       = 3'd4,
    TGT_NAMETABLE = 3'd5
  } target_e;

  localparam logic [CfgIdxW-1:0] CFG_PRG_BANK_COUNT = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_HAS_PRG_RAM    = 1'd1;

  localparam logic [CfgW-1:0] PRG_BANK_COUNT_RST = 7'd64;

  // bank select codes for the two PRG bank registers
  localparam logic [2:0] SEL_PRG_FIRST  = 3'd6;
  localparam logic [2:0] SEL_PRG_SECOND = 3'd7;

endpackage

// ===== rtl/bank_switch_mapper_scanline_irq_unit.sv =====
// ----------------------------------------------------------------------------
// bank_switch_mapper_scanline_irq_unit
// Cartridge bank mapper: register writes, CPU/PPU address translation and
// a scanline counter stepped by KIND_A12_EDGE requests.
// Result registered: valid in the cycle after the request is accepted.
// Throughput: 1 request per cycle unless out_ready_i stalls; all decode sits between
//   the request port and the result register, state updates at the accepting edge.
// Reset: async active low; all mapper state, config and valid cleared to
//   reset values, no clearing pass.
// ----------------------------------------------------------------------------
module bank_switch_mapper_scanline_irq_unit
  import bsm_pkg::*;
#(
  parameter int unsigned PRG_BANK_BITS = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgW-1:0]      cfg_data_i,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           kind_i,
  input  logic [AddrW-1:0]     address_i,
  input  logic [DataW-1:0]     data_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           target_o,
  output logic [OffsetW-1:0]   offset_o,
  output logic                 irq_pending_o
);

  localparam int unsigned PB = PRG_BANK_BITS;
  // number of banks that fit the bank register width
  localparam logic [CfgW-1:0] BankTop = CfgW'(1 << PRG_BANK_BITS);

  // --------------------------------------------------------------------------
  // Configuration registers; the port never stalls.
  // --------------------------------------------------------------------------
  logic [CfgW-1:0] prg_bank_count_q;
  logic            has_prg_ram_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_bank_count_q <= PRG_BANK_COUNT_RST;
      has_prg_ram_q    <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PRG_BANK_COUNT: prg_bank_count_q <= cfg_data_i;
        CFG_HAS_PRG_RAM:    has_prg_ram_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: a plain output register; a new request goes in whenever the
  // held result leaves in the same cycle or nothing is held.
  // --------------------------------------------------------------------------
  logic  out_valid_q;
  logic  accept;
  kind_e kind;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign kind       = kind_e'(kind_i);

  // --------------------------------------------------------------------------
  // Mapper state
  // --------------------------------------------------------------------------
  logic [2:0]    bank_sel_q,   bank_sel_d;
  logic          prg_swap_q,   prg_swap_d;
  logic          chr_inv_q,    chr_inv_d;
  logic [7:0]    chr_bank_q [6];
  logic [7:0]    chr_bank_d [6];
  logic [PB-1:0] prg_first_q,  prg_first_d;
  logic [PB-1:0] prg_second_q, prg_second_d;
  logic          mirror_h_q,   mirror_h_d;
  logic [7:0]    irq_latch_q,  irq_latch_d;
  logic [7:0]    irq_count_q,  irq_count_d;
  logic          ctr_reload_q, ctr_reload_d;
  logic          irq_dis_q,    irq_dis_d;
  logic          irq_flag_q,   irq_flag_d;

  logic addr_even;
  assign addr_even = !address_i[0];

  // Register writes and scanline counter. Writes below 0x8000 fall through.
  always_comb begin
    bank_sel_d   = bank_sel_q;
    prg_swap_d   = prg_swap_q;
    chr_inv_d    = chr_inv_q;
    chr_bank_d   = chr_bank_q;
    prg_first_d  = prg_first_q;
    prg_second_d = prg_second_q;
    mirror_h_d   = mirror_h_q;
    irq_latch_d  = irq_latch_q;
    irq_count_d  = irq_count_q;
    ctr_reload_d = ctr_reload_q;
    irq_dis_d    = irq_dis_q;
    irq_flag_d   = irq_flag_q;
    if (kind == KIND_CPU_WRITE && address_i[15]) begin
      // address bits 14:13 pick the 8KB register window
      unique case (address_i[14:13])
        2'b00: begin
          if (addr_even) begin
            bank_sel_d = data_i[2:0];
            prg_swap_d = data_i[6];
            chr_inv_d  = data_i[7];
          end else begin
            priority case (bank_sel_q)
              3'd0, 3'd1: chr_bank_d[bank_sel_q] = {data_i[7:1], 1'b0};  // 2KB banks
              SEL_PRG_FIRST:  prg_first_d  = data_i[PB-1:0];
              SEL_PRG_SECOND: prg_second_d = data_i[PB-1:0];
              default:        chr_bank_d[bank_sel_q] = data_i;
            endcase
          end
        end
        2'b01: begin
          // odd address is RAM protect, left to the memory side
          if (addr_even) mirror_h_d = data_i[0];
        end
        2'b10: begin
          if (addr_even) begin
            irq_latch_d = data_i;
          end else begin
            irq_count_d  = '0;
            ctr_reload_d = 1'b1;
          end
        end
        default: begin
          irq_dis_d = addr_even;
          if (addr_even) irq_flag_d = 1'b0;
        end
      endcase
    end else if (kind == KIND_A12_EDGE) begin
      if (irq_count_q == '0 || ctr_reload_q) begin
        irq_count_d  = irq_latch_q;
        ctr_reload_d = 1'b0;
      end else begin
        irq_count_d = irq_count_q - 8'd1;
      end
      if (irq_count_d == '0 && !irq_dis_q) irq_flag_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_sel_q   <= '0;
      prg_swap_q   <= 1'b0;
      chr_inv_q    <= 1'b0;
      chr_bank_q   <= '{default: '0};
      prg_first_q  <= '0;
      prg_second_q <= '0;
      mirror_h_q   <= 1'b1;
      irq_latch_q  <= '0;
      irq_count_q  <= '0;
      ctr_reload_q <= 1'b0;
      irq_dis_q    <= 1'b0;
      irq_flag_q   <= 1'b0;
    end else if (accept) begin
      bank_sel_q   <= bank_sel_d;
      prg_swap_q   <= prg_swap_d;
      chr_inv_q    <= chr_inv_d;
      chr_bank_q   <= chr_bank_d;
      prg_first_q  <= prg_first_d;
      prg_second_q <= prg_second_d;
      mirror_h_q   <= mirror_h_d;
      irq_latch_q  <= irq_latch_d;
      irq_count_q  <= irq_count_d;
      ctr_reload_q <= ctr_reload_d;
      irq_dis_q    <= irq_dis_d;
      irq_flag_q   <= irq_flag_d;
    end
  end

  // --------------------------------------------------------------------------
  // CPU translation. Bank count is clamped to 2..2^PB before placing the
  // fixed last two banks.
  // --------------------------------------------------------------------------
  logic [CfgW-1:0] bank_count;
  logic [PB-1:0]   bank_last, bank_second_last, prg_bank;
  target_e         cpu_tgt;
  logic [OffsetW-1:0] cpu_off;

  always_comb begin
    if (prg_bank_count_q < CfgW'(2))      bank_count = CfgW'(2);
    else if (prg_bank_count_q > BankTop) bank_count = BankTop;
    else                                 bank_count = prg_bank_count_q;
    bank_last        = PB'(bank_count - CfgW'(1));
    bank_second_last = PB'(bank_count - CfgW'(2));
  end

  always_comb begin
    unique case (address_i[14:13])
      2'b11:   prg_bank = bank_last;
      2'b10:   prg_bank = prg_swap_q ? prg_first_q : bank_second_last;
      2'b01:   prg_bank = prg_second_q;
      default: prg_bank = prg_swap_q ? bank_second_last : prg_first_q;
    endcase
  end

  always_comb begin
    cpu_tgt = TGT_NONE;
    cpu_off = '0;
    if (address_i[15]) begin
      cpu_tgt = TGT_PRG_ROM;
      cpu_off = OffsetW'({prg_bank, address_i[12:0]});
    end else if (address_i[15:13] == 3'b000) begin
      cpu_tgt = TGT_CPU_RAM;  // 2KB mirrored
      cpu_off = OffsetW'(address_i[10:0]);
    end else if (address_i[15:13] == 3'b011 && has_prg_ram_q) begin
      cpu_tgt = TGT_PRG_RAM;
      cpu_off = OffsetW'(address_i[12:0]);
    end
  end

  // --------------------------------------------------------------------------
  // PPU translation: CHR windows (inversion swaps the two 4KB halves),
  // nametables with 0x3000 folding onto 0x2000, palette and up give none.
  // --------------------------------------------------------------------------
  logic [12:0]        chr_addr;
  logic [2:0]         chr_idx;
  logic [7:0]         chr_bank;
  logic [11:0]        nt_addr;
  target_e            ppu_tgt;
  logic [OffsetW-1:0] ppu_off;

  assign chr_addr = {address_i[12] ^ chr_inv_q, address_i[11:0]};
  assign chr_idx  = chr_addr[12] ? (3'd2 + {1'b0, chr_addr[11:10]}) : {2'b00, chr_addr[11]};
  assign chr_bank = chr_bank_q[chr_idx];
  assign nt_addr  = address_i[11:0];

  always_comb begin
    ppu_tgt = TGT_NONE;
    ppu_off = '0;
    if (address_i[15:8] >= 8'h3F) begin
      ppu_tgt = TGT_NONE;
    end else if (!address_i[13]) begin
      ppu_tgt = TGT_CHR;
      if (chr_addr[12]) begin
        ppu_off = OffsetW'({chr_bank, chr_addr[9:0]});
      end else begin
        ppu_off = OffsetW'({chr_bank, 10'd0}) + OffsetW'(chr_addr[10:0]);
      end
    end else begin
      ppu_tgt = TGT_NAMETABLE;
      if (mirror_h_q) ppu_off = OffsetW'({nt_addr[11], nt_addr[9:0]});
      else            ppu_off = OffsetW'(nt_addr[10:0]);
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  target_e            res_tgt;
  logic [OffsetW-1:0] res_off;
  target_e            tgt_q;
  logic [OffsetW-1:0] off_q;
  logic               irq_out_q;

  always_comb begin
    unique case (kind)
      KIND_CPU_MAP: begin
        res_tgt = cpu_tgt;
        res_off = cpu_off;
      end
      KIND_PPU_MAP: begin
        res_tgt = ppu_tgt;
        res_off = ppu_off;
      end
      default: begin
        res_tgt = TGT_NONE;
        res_off = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tgt_q     <= res_tgt;
      off_q     <= res_off;
      irq_out_q <= irq_flag_d;  // level after this event
    end
  end

  assign out_valid_o   = out_valid_q;
  assign target_o      = tgt_q;
  assign offset_o      = off_q;
  assign irq_pending_o = irq_out_q;

endmodule

// ===== rtl/bsm_checker.sv =====
// ----------------------------------------------------------------------------
// bsm_checker
// Port-level checks of the mapper, bound to the top level.
// ----------------------------------------------------------------------------
`include "bank_switch_mapper_scanline_irq_unit_defines.svh"

module bsm_checker
  import bsm_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         kind_i,
  input logic [AddrW-1:0]   address_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [2:0]         target_o,
  input logic [OffsetW-1:0] offset_o
);

  logic in_acc;
  logic in_acc_quiet;
  logic in_acc_ram;

  assign in_acc       = in_valid_i && in_ready_o;
  assign in_acc_quiet = in_acc && (kind_i == KIND_CPU_WRITE || kind_i == KIND_A12_EDGE);
  assign in_acc_ram   = in_acc && kind_i == KIND_CPU_MAP && address_i[15:13] == 3'b000;

  `BSM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `BSM_ASSERT_NEXT(a_one_cycle, in_acc, out_valid_o)
  `BSM_ASSERT_NEXT(a_quiet_none, in_acc_quiet, target_o == TGT_NONE && offset_o == '0)
  `BSM_ASSERT_NEXT(a_cpu_ram, in_acc_ram, target_o == TGT_CPU_RAM && offset_o[18:11] == '0)

endmodule

bind bank_switch_mapper_scanline_irq_unit bsm_checker u_bsm_checker (.*);
